/* rtl/tct_pkg.sv */
// Shared types and constants of the TCP connection tracker.
package tct_pkg;

  localparam int HASH_BITS_DEF = 10;
  localparam int WAYS_DEF = 4;
  localparam int CNT_OUT_W = 13;
  localparam logic [15:0] LIMIT_DEF = 16'd65535;
  localparam logic [15:0] TIMEOUT_DEF = 16'd60;
  localparam int CFG_IDX_W = 8;

  typedef enum logic [2:0] {
    ACT_SYN_SENT    = 3'd0,
    ACT_SYNACK      = 3'd1,
    ACT_ESTABLISHED = 3'd2,
    ACT_TEARDOWN    = 3'd3,
    ACT_TICK        = 3'd4,
    ACT_SWEEP       = 3'd5,
    ACT_CLEAR       = 3'd6,
    ACT_NOP         = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_LIMIT     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_SYN_SENT    = 2'd0,
    PH_SYNACK      = 2'd1,
    PH_ESTABLISHED = 2'd2,
    PH_UNUSED      = 2'd3
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ENTRIES   = 8'd0,
    REG_STALE_TIMEOUT = 8'd1
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port_num;
    logic [15:0] dst_port_num;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] active_count;
    logic [CNT_OUT_W-1:0] removed_count;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] addrs;
    logic [31:0] ports;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [1:0]  phase;
    logic [31:0] stamp;
  } slot_t;

endpackage

/* rtl/tct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tct_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tcp_connection_tracker.sv */
// Hashed bucket table of TCP connections with sweep and clear.
// Key actions: the bucket row is read on acceptance, modified and written back in the probe state, then the result.
// Tick and unused codes go straight to the result. Clear: one row write a cycle.
// Sweep: one row read and one row write-back per bucket.
// One transaction in flight; the next is accepted while a result waits in the output register.
// Reset: a clearing pass over all rows zeroes the valid bits; no input accepted then.
module tcp_connection_tracker
  import tct_pkg::*;
#(
  parameter int HASH_BITS = HASH_BITS_DEF,
  parameter int WAYS = WAYS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i
);

  localparam int Rows = 1 << HASH_BITS;
  localparam int NumSlots = Rows * WAYS;
  localparam int CntW = $clog2(NumSlots + 1);
  localparam int CmpW = (CntW > 16) ? CntW : 16;
  localparam int WayW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RowW = WAYS * $bits(slot_t);

  typedef enum logic [6:0] {
    S_INIT    = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_PROBE   = 7'b0000100,
    S_SCAN_RD = 7'b0001000,
    S_SCAN_WR = 7'b0010000,
    S_CLEAR   = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [HASH_BITS-1:0] row_q, row_d;
  logic [CntW-1:0]     vt_q, vt_d;
  logic [CntW-1:0]     rem_q, rem_d;
  logic [31:0]         sec_q, sec_d;
  logic [1:0]          status_q, status_d;
  logic [15:0]         max_q, tmo_q;
  in_item_t            item_q;
  logic [HASH_BITS-1:0] bucket_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic                 ram_we;
  logic [HASH_BITS-1:0] ram_waddr, ram_raddr;
  logic [RowW-1:0]      ram_wdata, ram_rdata;
  slot_t [WAYS-1:0]     row_rd, row_mod, row_swept;

  logic [31:0]          hash_x, hash_f;
  logic [HASH_BITS-1:0] bucket_in;
  logic                 hit, free;
  logic [WayW-1:0]      hit_way, free_way;
  logic [WAYS-1:0]      stale;
  logic [CntW-1:0]      stale_cnt;
  logic [15:0]          limit, tmo;
  logic                 last_row, load_out;

  tct_ram #(
    .Width(RowW),
    .Depth(Rows)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign row_rd = ram_rdata;

  assign hash_x = in_item_i.src_addr ^ in_item_i.dst_addr ^
                  {in_item_i.src_port_num, in_item_i.dst_port_num};
  assign hash_f = hash_x ^ (hash_x >> 16) ^ (hash_x >> 8);
  assign bucket_in = hash_f[HASH_BITS-1:0];

  assign limit = (max_q == '0) ? LIMIT_DEF : max_q;
  assign tmo = (tmo_q == '0) ? TIMEOUT_DEF : tmo_q;
  assign last_row = (row_q == {HASH_BITS{1'b1}});

  always_comb begin
    hit = 1'b0;
    hit_way = '0;
    free = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_rd[w].valid && row_rd[w].addrs == {item_q.src_addr, item_q.dst_addr} &&
          row_rd[w].ports == {item_q.src_port_num, item_q.dst_port_num}) begin
        hit = 1'b1;
        hit_way = WayW'(w);
      end
      if (!row_rd[w].valid) begin
        free = 1'b1;
        free_way = WayW'(w);
      end
    end
  end

  always_comb begin
    row_swept = row_rd;
    for (int w = 0; w < WAYS; w++) begin
      stale[w] = row_rd[w].valid && ((sec_q - row_rd[w].stamp) > {16'd0, tmo});
      if (stale[w]) begin
        row_swept[w].valid = 1'b0;
      end
    end
    stale_cnt = CntW'($countones(stale));
  end

  always_comb begin
    state_d = state_q;
    row_d = row_q;
    vt_d = vt_q;
    rem_d = rem_q;
    sec_d = sec_q;
    status_d = status_q;
    ram_we = 1'b0;
    ram_waddr = bucket_q;
    ram_raddr = bucket_in;
    row_mod = row_rd;
    ram_wdata = row_mod;
    load_out = 1'b0;
    unique case (state_q)
      S_INIT: begin
        ram_we = 1'b1;
        ram_waddr = row_q;
        ram_wdata = '0;
        row_d = row_q + 1'b1;
        if (last_row) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = ST_OK;
          rem_d = '0;
          row_d = '0;
          unique case (action_e'(in_item_i.action))
            ACT_SYN_SENT, ACT_SYNACK, ACT_ESTABLISHED, ACT_TEARDOWN: state_d = S_PROBE;
            ACT_TICK: begin
              sec_d = sec_q + 32'd1;
              state_d = S_DONE;
            end
            ACT_SWEEP: state_d = S_SCAN_RD;
            ACT_CLEAR: state_d = S_CLEAR;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_PROBE: begin
        unique case (action_e'(item_q.action))
          ACT_SYN_SENT: begin
            if (CmpW'(vt_q) >= CmpW'(limit)) begin
              status_d = ST_LIMIT;
            end else if (!hit) begin
              if (free) begin
                row_mod[free_way].valid = 1'b1;
                row_mod[free_way].addrs = {item_q.src_addr, item_q.dst_addr};
                row_mod[free_way].ports = {item_q.src_port_num, item_q.dst_port_num};
                row_mod[free_way].seq = item_q.seq_num;
                row_mod[free_way].ack = '0;
                row_mod[free_way].phase = PH_SYN_SENT;
                row_mod[free_way].stamp = sec_q;
                ram_we = 1'b1;
                vt_d = vt_q + 1'b1;
              end else begin
                status_d = ST_FULL;
              end
            end
          end
          ACT_SYNACK: begin
            if (hit) begin
              row_mod[hit_way].seq = item_q.seq_num;
              row_mod[hit_way].ack = item_q.ack_num;
              row_mod[hit_way].phase = PH_SYNACK;
              row_mod[hit_way].stamp = sec_q;
              ram_we = 1'b1;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          ACT_ESTABLISHED: begin
            if (hit) begin
              row_mod[hit_way].phase = PH_ESTABLISHED;
              row_mod[hit_way].stamp = sec_q;
              ram_we = 1'b1;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          ACT_TEARDOWN: begin
            if (hit) begin
              row_mod[hit_way].valid = 1'b0;
              ram_we = 1'b1;
              vt_d = vt_q - 1'b1;
            end
          end
          default: ;
        endcase
        ram_wdata = row_mod;
        state_d = S_DONE;
      end
      S_SCAN_RD: begin
        ram_raddr = row_q;
        state_d = S_SCAN_WR;
      end
      S_SCAN_WR: begin
        ram_we = 1'b1;
        ram_waddr = row_q;
        ram_wdata = row_swept;
        vt_d = vt_q - stale_cnt;
        rem_d = rem_q + stale_cnt;
        row_d = row_q + 1'b1;
        state_d = last_row ? S_DONE : S_SCAN_RD;
      end
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = row_q;
        ram_wdata = '0;
        row_d = row_q + 1'b1;
        if (last_row) begin
          vt_d = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      row_q <= '0;
      vt_q <= '0;
      rem_q <= '0;
      sec_q <= '0;
      status_q <= ST_OK;
      max_q <= LIMIT_DEF;
      tmo_q <= TIMEOUT_DEF;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q <= row_d;
      vt_q <= vt_d;
      rem_q <= rem_d;
      sec_q <= sec_d;
      status_q <= status_d;
      if (cfg_we_i && cfg_idx_i == REG_MAX_ENTRIES) begin
        max_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == REG_STALE_TIMEOUT) begin
        tmo_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      item_q <= in_item_i;
      bucket_q <= bucket_in;
    end
    if (load_out) begin
      out_q.status <= status_q;
      out_q.active_count <= CNT_OUT_W'(vt_q);
      out_q.removed_count <= CNT_OUT_W'(rem_q);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !ram_we)
    else $error("table written while idle");

  a_probe_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PROBE |-> $past(state_q) == S_IDLE)
    else $error("probe without a read issued");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vt_q <= CntW'(NumSlots))
    else $error("active count beyond table size");

  a_load_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && state_q == S_IDLE)
    else $error("result load out of sequence");

endmodule
